FILE: hdl/abks_pkg.sv
// Shared types, codes and constants for the A/B key slot record manager.
// Holds the byte-wide reflected CRC-32 step used by the record parser.
// No dependencies.
package abks_pkg;

    // Default geometry of a slot record
    localparam int DEFAULT_MAX_KEY_BYTES = 32;

    // Record layout: magic byte, then four generation bytes, then key bytes
    localparam int KEY_START = 5;
    localparam int CRC_BYTES = 4;

    // Width used when comparing key lengths (width of new_key_length)
    localparam int CMP_W = 8;

    // Register reset values
    localparam logic [7:0] RECORD_MAGIC_RESET   = 8'd165;
    localparam logic [5:0] MIN_KEY_LENGTH_RESET = 6'd16;

    // Configuration register indexes
    localparam logic REG_RECORD_MAGIC   = 1'b0;
    localparam logic REG_MIN_KEY_LENGTH = 1'b1;

    // Constants of the record format
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [7:0]  PAD_BYTE = 8'hFF;

    // Input actions
    localparam logic [1:0] ACT_START_SCAN = 2'd0;
    localparam logic [1:0] ACT_RECORD     = 2'd1;
    localparam logic [1:0] ACT_ROTATE     = 2'd2;
    localparam logic [1:0] ACT_WIPE       = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_BAD_INPUT = 2'd2;
    localparam logic [1:0] ST_STALE     = 2'd3;

    // Result word: fields from the highest bit down
    typedef struct packed {
        logic [5:0]  active_key_length;
        logic        live_slot;
        logic [31:0] active_generation;
        logic        active_present;
        logic        rotate_slot;
        logic [5:0]  record_key_length;
        logic [31:0] record_generation;
        logic        record_valid;
    } result_t;

    // One byte through the reflected CRC-32, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/ab_key_slot_record_manager_unit.sv
// Top level of the A/B key slot record manager: record parser with CRC-32
// check, active slot tracking, rotate and wipe handling, APB register port.
// Depends on abks_pkg.

// The block takes one word per clock on the input stream while s_axis_tready is
// high and returns at most one result word per input word: start scan, rotate
// and wipe always return one, a record byte returns one only when it is the last
// byte of a 5 + MAX_KEY_BYTES + 4 byte record (41 bytes by default). The
// byte-wide CRC-32 step, the record field shifters and the active-slot compare
// all sit combinationally between the state registers and the result register,
// so only a full output buffer holds off the input. A two-entry output buffer
// lets input run while a result waits; s_axis_tready drops only when both
// entries are full. The record belongs to the slot given with its last byte.
// Configuration registers (record_magic at 0x0, min_key_length at 0x4) are
// written over APB and may only change while the stream is idle.
module ab_key_slot_record_manager_unit #(
    parameter int MAX_KEY_BYTES = abks_pkg::DEFAULT_MAX_KEY_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] record_byte, [39:8] new_generation, [47:40] new_key_length
    input  logic [47:0] s_axis_tdata,
    // [1:0] action, [2] rec_slot
    input  logic [2:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] record_valid, [32:1] record_generation, [38:33] record_key_length,
    // [39] rotate_slot, [40] active_present, [72:41] active_generation,
    // [73] live_slot, [79:74] active_key_length
    output logic [79:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CRC_START    = abks_pkg::KEY_START + MAX_KEY_BYTES;
    localparam int RECORD_BYTES = CRC_START + abks_pkg::CRC_BYTES;
    localparam int POS_W        = $clog2(RECORD_BYTES);
    localparam int LEN_W        = $clog2(MAX_KEY_BYTES + 1);
    localparam int CW           = abks_pkg::CMP_W;

    // ---------------- configuration registers ----------------
    logic [7:0] record_magic_reg;
    logic [5:0] min_key_length_reg;
    logic       cfg_write;
    logic       cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_magic_reg   <= abks_pkg::RECORD_MAGIC_RESET;
            min_key_length_reg <= abks_pkg::MIN_KEY_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == abks_pkg::REG_RECORD_MAGIC)
                record_magic_reg <= pwdata[7:0];
            else
                min_key_length_reg <= pwdata[5:0];
        end
    end

    always_comb
    begin
        if (cfg_index == abks_pkg::REG_RECORD_MAGIC)
            prdata = {24'h0, record_magic_reg};
        else
            prdata = {26'h0, min_key_length_reg};
    end

    // ---------------- input word fields ----------------
    logic [1:0]  action;
    logic        rec_slot;
    logic [7:0]  record_byte;
    logic [31:0] new_generation;
    logic [7:0]  new_key_length;
    logic        accept;

    assign action         = s_axis_tuser[1:0];
    assign rec_slot       = s_axis_tuser[2];
    assign record_byte    = s_axis_tdata[7:0];
    assign new_generation = s_axis_tdata[39:8];
    assign new_key_length = s_axis_tdata[47:40];
    assign accept         = s_axis_tvalid && s_axis_tready;

    // ---------------- parser and active state ----------------
    logic [31:0]      crc_reg, crc_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             magic_ok_reg, magic_ok_next;
    logic [31:0]      gen_shift_reg, gen_shift_next;
    logic [31:0]      crc_shift_reg, crc_shift_next;
    logic [LEN_W-1:0] last_np_reg, last_np_next;
    logic             active_reg, active_next;
    logic [31:0]      act_gen_reg, act_gen_next;
    logic [LEN_W-1:0] act_len_reg, act_len_next;
    logic             act_slot_reg, act_slot_next;

    logic             emit;
    logic [1:0]       res_status;
    logic             res_rvalid;
    logic [31:0]      res_rgen;
    logic [5:0]       res_rlen;
    logic             res_target;

    logic [31:0]      stored_crc;
    logic             rec_ok;
    logic [CW-1:0]    klen;
    logic [CW-1:0]    min_ext;
    logic [CW-1:0]    max_ext;
    logic             len_bad;

    assign stored_crc = {crc_shift_reg[23:0], record_byte};
    assign rec_ok     = magic_ok_reg && ((crc_reg ^ abks_pkg::ALL_ONES) == stored_crc);
    assign min_ext    = CW'(min_key_length_reg);
    assign max_ext    = CW'(MAX_KEY_BYTES);
    assign len_bad    = (new_key_length < min_ext) || (new_key_length > max_ext);

    // Key length: stripped length, raised to the minimum, capped at the key area
    always_comb
    begin
        klen = CW'(last_np_reg);
        if (klen < min_ext)
            klen = min_ext;
        if (klen > max_ext)
            klen = max_ext;
    end

    always_comb
    begin
        crc_next       = crc_reg;
        pos_next       = pos_reg;
        magic_ok_next  = magic_ok_reg;
        gen_shift_next = gen_shift_reg;
        crc_shift_next = crc_shift_reg;
        last_np_next   = last_np_reg;
        active_next    = active_reg;
        act_gen_next   = act_gen_reg;
        act_len_next   = act_len_reg;
        act_slot_next  = act_slot_reg;
        emit           = 1'b0;
        res_status     = abks_pkg::ST_OK;
        res_rvalid     = 1'b0;
        res_rgen       = 32'h0;
        res_rlen       = 6'h0;
        res_target     = 1'b0;

        if (accept)
        begin
            case (action)
                abks_pkg::ACT_RECORD:
                begin
                    if (pos_reg < POS_W'(CRC_START))
                        crc_next = abks_pkg::crc_byte(crc_reg, record_byte);
                    if (pos_reg == '0)
                        magic_ok_next = (record_byte == record_magic_reg);
                    else if (pos_reg < POS_W'(abks_pkg::KEY_START))
                        gen_shift_next = {gen_shift_reg[23:0], record_byte};
                    else if (pos_reg < POS_W'(CRC_START))
                    begin
                        if (record_byte != abks_pkg::PAD_BYTE)
                            last_np_next = LEN_W'(pos_reg - POS_W'(abks_pkg::KEY_START - 1));
                    end
                    else
                        crc_shift_next = stored_crc;

                    if (pos_reg != POS_W'(RECORD_BYTES - 1))
                        pos_next = pos_reg + POS_W'(1);
                    else
                    begin
                        // Record complete: report it and restart the parser
                        emit       = 1'b1;
                        res_rvalid = rec_ok;
                        res_rgen   = gen_shift_reg;
                        res_rlen   = 6'(klen);
                        if (rec_ok && (!active_reg || gen_shift_reg > act_gen_reg))
                        begin
                            active_next   = 1'b1;
                            act_gen_next  = gen_shift_reg;
                            act_len_next  = LEN_W'(klen);
                            act_slot_next = rec_slot;
                        end
                        crc_next       = abks_pkg::ALL_ONES;
                        pos_next       = '0;
                        magic_ok_next  = 1'b0;
                        gen_shift_next = 32'h0;
                        crc_shift_next = 32'h0;
                        last_np_next   = '0;
                        res_status     = (rec_ok || active_reg) ? abks_pkg::ST_OK
                                                                : abks_pkg::ST_EMPTY;
                    end
                end
                abks_pkg::ACT_ROTATE:
                begin
                    emit = 1'b1;
                    if (len_bad)
                        res_status = abks_pkg::ST_BAD_INPUT;
                    else if (active_reg && new_generation <= act_gen_reg)
                        res_status = abks_pkg::ST_STALE;
                    else
                    begin
                        res_target    = active_reg ? ~act_slot_reg : 1'b0;
                        active_next   = 1'b1;
                        act_gen_next  = new_generation;
                        act_len_next  = LEN_W'(new_key_length);
                        act_slot_next = active_reg ? ~act_slot_reg : 1'b0;
                        res_status    = abks_pkg::ST_OK;
                    end
                end
                default:
                begin
                    // Start scan and wipe: clear active state, restart parser
                    emit           = 1'b1;
                    res_status     = (action == abks_pkg::ACT_START_SCAN) ? abks_pkg::ST_EMPTY
                                                                          : abks_pkg::ST_OK;
                    active_next    = 1'b0;
                    act_gen_next   = 32'h0;
                    act_len_next   = '0;
                    act_slot_next  = 1'b0;
                    crc_next       = abks_pkg::ALL_ONES;
                    pos_next       = '0;
                    magic_ok_next  = 1'b0;
                    gen_shift_next = 32'h0;
                    crc_shift_next = 32'h0;
                    last_np_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= abks_pkg::ALL_ONES;
            pos_reg       <= '0;
            magic_ok_reg  <= 1'b0;
            gen_shift_reg <= 32'h0;
            crc_shift_reg <= 32'h0;
            last_np_reg   <= '0;
            active_reg    <= 1'b0;
            act_gen_reg   <= 32'h0;
            act_len_reg   <= '0;
            act_slot_reg  <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            pos_reg       <= pos_next;
            magic_ok_reg  <= magic_ok_next;
            gen_shift_reg <= gen_shift_next;
            crc_shift_reg <= crc_shift_next;
            last_np_reg   <= last_np_next;
            active_reg    <= active_next;
            act_gen_reg   <= act_gen_next;
            act_len_reg   <= act_len_next;
            act_slot_reg  <= act_slot_next;
        end
    end

    // ---------------- result word and output buffer ----------------
    abks_pkg::result_t res_word;

    // Active fields are already zero whenever no key is active
    always_comb
    begin
        res_word.record_valid      = res_rvalid;
        res_word.record_generation = res_rgen;
        res_word.record_key_length = res_rlen;
        res_word.rotate_slot       = res_target;
        res_word.active_present    = active_next;
        res_word.active_generation = act_gen_next;
        res_word.live_slot         = act_slot_next;
        res_word.active_key_length = 6'(act_len_next);
    end

    logic              out_valid_reg;
    abks_pkg::result_t out_data_reg;
    logic [1:0]        out_user_reg;
    logic              skid_valid_reg;
    abks_pkg::result_t skid_data_reg;
    logic [1:0]        skid_user_reg;
    logic              out_load;
    logic              res_valid;

    assign res_valid     = accept && emit;
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            // Drain the skid entry first; input is held off while it is full
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= res_valid;
        end
        else if (res_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
            else if (res_valid)
            begin
                out_data_reg <= res_word;
                out_user_reg <= res_status;
            end
        end
        else if (res_valid)
        begin
            skid_data_reg <= res_word;
            skid_user_reg <= res_status;
        end
    end

endmodule
